// ----- sv/ple_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Sizes, command and status codes, and the control word that drives the
// row of storage cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;
  localparam int ELEM_W  = 32;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CMP_W   = POS_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FIRST = 3'd0,
    CMD_INS_LAST  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_LAST  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_HOLD = 2'd0,
    MODE_INS  = 2'd1,
    MODE_DEL  = 2'd2,
    MODE_ROT  = 2'd3
  } shift_mode_t;

  typedef struct packed {
    shift_mode_t           mode;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] word;
  } cell_ctl_t;

endpackage

// ----- sv/ple_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_chan_if: command and result channels of the positional list engine
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [ple_pkg::CMD_W-1:0]           command;
  logic signed [ple_pkg::VALUE_W-1:0]  value;
  logic [ple_pkg::POS_W-1:0]           position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface ple_res_if;
  logic                                valid;
  logic                                ready;
  logic [ple_pkg::STAT_W-1:0]          status;
  logic [ple_pkg::CNT_W-1:0]           entry_count;
  logic signed [ple_pkg::ELEM_W-1:0]   element;
  logic                                element_valid;
  logic                                last;

  modport source (output valid, status, entry_count, element, element_valid, last,
                  input ready);
  modport sink   (input valid, status, entry_count, element, element_valid, last,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/ple_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list
// Holds one word and, each cycle, keeps it, loads the new word, or takes the
// word of its left neighbor, its right neighbor or the head of the list.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell (
  input  wire logic                               clk,
  input  wire logic [ple_pkg::IDX_W-1:0]          slot,
  input  wire ple_pkg::cell_ctl_t                 ctl,
  input  wire logic [ple_pkg::DATA_WIDTH-1:0]     left_word,
  input  wire logic [ple_pkg::DATA_WIDTH-1:0]     right_word,
  input  wire logic [ple_pkg::DATA_WIDTH-1:0]     head_word,
  output logic      [ple_pkg::DATA_WIDTH-1:0]     word
);

  logic [ple_pkg::DATA_WIDTH-1:0] word_next;

  always_comb begin
    word_next = word;
    case (ctl.mode)
      ple_pkg::MODE_INS: begin
        if (slot == ctl.idx) begin
          word_next = ctl.word;
        end else if (slot > ctl.idx) begin
          word_next = left_word;
        end
      end
      ple_pkg::MODE_DEL: begin
        if (slot >= ctl.idx) begin
          word_next = right_word;
        end
      end
      ple_pkg::MODE_ROT: begin
        if (slot == ctl.idx) begin
          word_next = head_word;
        end else if (slot < ctl.idx) begin
          word_next = right_word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

// ----- sv/ple_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl: command decode, fill count and result register
// Checks each command against the fill count, steers the cell row, and
// streams a dump by rotating the filled part of the row one place per item.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  ple_cmd_if.sink                              cmd_ch,
  ple_res_if.source                            res_ch,
  input  wire logic [ple_pkg::DATA_WIDTH-1:0]  head_word,
  output ple_pkg::cell_ctl_t                   ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                      state;
  logic                        out_valid;
  logic [ple_pkg::CNT_W-1:0]   count;
  logic [ple_pkg::CNT_W-1:0]   count_next;
  logic [ple_pkg::CNT_W-1:0]   remain;
  logic [ple_pkg::STAT_W-1:0]  status_q;
  logic [ple_pkg::CNT_W-1:0]   count_q;
  logic [ple_pkg::ELEM_W-1:0]  elem_q;
  logic                        elem_valid_q;
  logic                        last_q;

  ple_pkg::status_t            status_n;
  logic                        slot_free;
  logic                        take;
  logic                        emit;
  logic                        dump_start;
  logic                        full;
  logic                        empty;
  logic [ple_pkg::CMP_W-1:0]   pos_ext;
  logic [ple_pkg::CMP_W-1:0]   cnt_ext;
  logic [ple_pkg::IDX_W-1:0]   pos_idx;
  logic [ple_pkg::IDX_W-1:0]   tail_idx;

  assign slot_free    = !out_valid || res_ch.ready;
  assign cmd_ch.ready = (state == S_IDLE) && slot_free;
  assign take         = cmd_ch.valid && cmd_ch.ready;
  assign emit         = (state == S_DUMP) && slot_free;
  assign full         = (count == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign empty        = (count == '0);
  assign pos_ext      = ple_pkg::CMP_W'(cmd_ch.position);
  assign cnt_ext      = ple_pkg::CMP_W'(count);
  assign pos_idx      = ple_pkg::IDX_W'(cmd_ch.position - ple_pkg::POS_W'(1));
  assign tail_idx     = ple_pkg::IDX_W'(count - ple_pkg::CNT_W'(1));

  always_comb begin
    ctl.mode   = ple_pkg::MODE_HOLD;
    ctl.idx    = '0;
    ctl.word   = ple_pkg::DATA_WIDTH'(cmd_ch.value);
    status_n   = ple_pkg::ST_OK;
    count_next = count;
    dump_start = 1'b0;
    if (take) begin
      case (ple_pkg::cmd_t'(cmd_ch.command))
        ple_pkg::CMD_INS_FIRST, ple_pkg::CMD_INS_LAST, ple_pkg::CMD_INS_POS: begin
          if (full) begin
            status_n = ple_pkg::ST_FULL;
          end else if (ple_pkg::cmd_t'(cmd_ch.command) == ple_pkg::CMD_INS_POS &&
                       (pos_ext == '0 || pos_ext > cnt_ext + ple_pkg::CMP_W'(1))) begin
            status_n = ple_pkg::ST_BAD;
          end else begin
            ctl.mode   = ple_pkg::MODE_INS;
            count_next = count + ple_pkg::CNT_W'(1);
            case (ple_pkg::cmd_t'(cmd_ch.command))
              ple_pkg::CMD_INS_FIRST: ctl.idx = '0;
              ple_pkg::CMD_INS_LAST:  ctl.idx = ple_pkg::IDX_W'(count);
              default:                ctl.idx = pos_idx;
            endcase
          end
        end
        ple_pkg::CMD_DEL_FIRST, ple_pkg::CMD_DEL_LAST, ple_pkg::CMD_DEL_POS: begin
          if (empty) begin
            status_n = ple_pkg::ST_EMPTY;
          end else if (ple_pkg::cmd_t'(cmd_ch.command) == ple_pkg::CMD_DEL_POS &&
                       (pos_ext == '0 || pos_ext > cnt_ext)) begin
            status_n = ple_pkg::ST_BAD;
          end else begin
            ctl.mode   = ple_pkg::MODE_DEL;
            count_next = count - ple_pkg::CNT_W'(1);
            case (ple_pkg::cmd_t'(cmd_ch.command))
              ple_pkg::CMD_DEL_FIRST: ctl.idx = '0;
              ple_pkg::CMD_DEL_LAST:  ctl.idx = tail_idx;
              default:                ctl.idx = pos_idx;
            endcase
          end
        end
        ple_pkg::CMD_DUMP: begin
          if (empty) begin
            status_n = ple_pkg::ST_EMPTY;
          end else begin
            dump_start = 1'b1;
          end
        end
        default: begin
          status_n = ple_pkg::ST_OK;
        end
      endcase
    end else if (emit) begin
      ctl.mode = ple_pkg::MODE_ROT;
      ctl.idx  = tail_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      remain    <= '0;
    end else begin
      count <= count_next;
      if ((take && !dump_start) || emit) begin
        out_valid <= 1'b1;
      end else if (slot_free) begin
        out_valid <= 1'b0;
      end
      if (take && dump_start) begin
        state  <= S_DUMP;
        remain <= count;
      end
      if (emit) begin
        remain <= remain - ple_pkg::CNT_W'(1);
        if (remain == ple_pkg::CNT_W'(1)) begin
          state <= S_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !dump_start) begin
      status_q     <= status_n;
      count_q      <= count_next;
      elem_q       <= '0;
      elem_valid_q <= 1'b0;
      last_q       <= 1'b1;
    end else if (emit) begin
      status_q     <= ple_pkg::ST_OK;
      count_q      <= count;
      elem_q       <= ple_pkg::ELEM_W'(head_word);
      elem_valid_q <= 1'b1;
      last_q       <= (remain == ple_pkg::CNT_W'(1));
    end
  end

  assign res_ch.valid         = out_valid;
  assign res_ch.status        = status_q;
  assign res_ch.entry_count   = count_q;
  assign res_ch.element       = elem_q;
  assign res_ch.element_valid = elem_valid_q;
  assign res_ch.last          = last_q;

endmodule

`default_nettype wire

// ----- sv/positional_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed words in a row of cells
// Inserts and deletes at the front, the back or a position, and dumps the
// list in order, one result item per entry.
// ----------------------------------------------------------------------------
//   channel  direction  fields
//   cmd_ch   in         command, value, position
//   res_ch   out        status, entry_count, element, element_valid, last
//
// On an edit, every cell shifts or holds at the same edge, and its result
// item is offered in the next cycle.
// A dump holds the command side while it takes the command and emits one
// result item per entry; each result item rotates the filled part of the
// cell row by one place, so the list is back in order at the end.
// Reset clears the fill count and the control state; the cells need no clearing.
// A stalled result holds the engine; no command is taken during a dump.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine (
  input  wire logic  clk,
  input  wire logic  rst,
  ple_cmd_if.sink    cmd_ch,
  ple_res_if.source  res_ch
);

  logic [ple_pkg::DATA_WIDTH-1:0] words [ple_pkg::CAPACITY];
  ple_pkg::cell_ctl_t             ctl;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_ch),
    .res_ch    (res_ch),
    .head_word (words[0]),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
    ple_cell u_cell (
      .clk        (clk),
      .slot       (ple_pkg::IDX_W'(i)),
      .ctl        (ctl),
      .left_word  (words[(i == 0) ? 0 : i - 1]),
      .right_word (words[(i == ple_pkg::CAPACITY - 1) ? i : i + 1]),
      .head_word  (words[0]),
      .word       (words[i])
    );
  end

endmodule

`default_nettype wire

// ----- sim/positional_list_engine_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_checker: list predictor and result comparator
// Watches the command and result channels. Every accepted command updates a
// private copy of the list and queues the result items it should cause; every
// accepted result item is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------

module positional_list_engine_checker (
  input  logic clk,
  input  logic rst,
  ple_cmd_if   cmd_mon,
  ple_res_if   res_mon,
  output int   mismatches,
  output int   pending,
  output int   held_count
);
  import ple_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic [CNT_W-1:0]         entry_count;
    logic signed [ELEM_W-1:0] element;
    logic                     element_valid;
    logic                     last;
  } list_result_t;

  logic signed [DATA_WIDTH-1:0] held_words[$];
  list_result_t                 expected_results[$];
  int                           fail_total = 0;
  int                           waiting = 0;
  int                           list_size = 0;

  assign mismatches = fail_total;
  assign pending    = waiting;
  assign held_count = list_size;

  function automatic void expect_edit(status_t st);
    list_result_t r;
    r.status        = st;
    r.entry_count   = CNT_W'(held_words.size());
    r.element       = '0;
    r.element_valid = 1'b0;
    r.last          = 1'b1;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_command(logic [CMD_W-1:0] code,
                                          logic signed [VALUE_W-1:0] word,
                                          logic [POS_W-1:0] pos);
    int           size;
    list_result_t r;
    size = held_words.size();
    case (code)
      CMD_INS_FIRST: begin
        if (size >= CAPACITY) begin
          expect_edit(ST_FULL);
        end else begin
          held_words.push_front(word);
          expect_edit(ST_OK);
        end
      end
      CMD_INS_LAST: begin
        if (size >= CAPACITY) begin
          expect_edit(ST_FULL);
        end else begin
          held_words.push_back(word);
          expect_edit(ST_OK);
        end
      end
      CMD_INS_POS: begin
        if (size >= CAPACITY) begin
          expect_edit(ST_FULL);
        end else if (pos == 0 || int'(pos) > size + 1) begin
          expect_edit(ST_BAD);
        end else begin
          held_words.insert(int'(pos) - 1, word);
          expect_edit(ST_OK);
        end
      end
      CMD_DEL_FIRST: begin
        if (size == 0) begin
          expect_edit(ST_EMPTY);
        end else begin
          void'(held_words.pop_front());
          expect_edit(ST_OK);
        end
      end
      CMD_DEL_LAST: begin
        if (size == 0) begin
          expect_edit(ST_EMPTY);
        end else begin
          void'(held_words.pop_back());
          expect_edit(ST_OK);
        end
      end
      CMD_DEL_POS: begin
        if (size == 0) begin
          expect_edit(ST_EMPTY);
        end else if (pos == 0 || int'(pos) > size) begin
          expect_edit(ST_BAD);
        end else begin
          held_words.delete(int'(pos) - 1);
          expect_edit(ST_OK);
        end
      end
      CMD_DUMP: begin
        if (size == 0) begin
          expect_edit(ST_EMPTY);
        end else begin
          foreach (held_words[i]) begin
            r.status        = ST_OK;
            r.entry_count   = CNT_W'(size);
            r.element       = ELEM_W'(held_words[i]);
            r.element_valid = 1'b1;
            r.last          = (i == size - 1);
            expected_results.push_back(r);
          end
        end
      end
      default: begin
        expect_edit(ST_OK);
      end
    endcase
  endfunction

  function automatic void compare_result();
    list_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result item: status %0d, entry_count %0d, element %0d",
             res_mon.status, res_mon.entry_count, res_mon.element);
      fail_total++;
    end else begin
      want = expected_results.pop_front();
      if (res_mon.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, res_mon.status);
        fail_total++;
      end
      if (res_mon.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count,
               res_mon.entry_count);
        fail_total++;
      end
      if (res_mon.element !== want.element) begin
        $error("element: expected %0d, actual %0d", want.element, res_mon.element);
        fail_total++;
      end
      if (res_mon.element_valid !== want.element_valid) begin
        $error("element_valid: expected %0d, actual %0d", want.element_valid,
               res_mon.element_valid);
        fail_total++;
      end
      if (res_mon.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, res_mon.last);
        fail_total++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_words.delete();
      expected_results.delete();
    end else begin
      if (cmd_mon.valid && cmd_mon.ready) begin
        predict_command(cmd_mon.command, cmd_mon.value, cmd_mon.position);
      end
      if (res_mon.valid && res_mon.ready) begin
        compare_result();
      end
    end
    waiting   = expected_results.size();
    list_size = held_words.size();
  end

endmodule

// ----- sim/positional_list_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb: stimulus and verdict for the list engine
// Runs a short directed sequence over the empty, bad-position and dump cases,
// then random commands that sweep the list between empty and full, with
// random gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int                 RUN_LIMIT    = 2_000_000;
  localparam int                 TAIL_CYCLES  = 100;
  localparam int                 RANDOM_ITEMS = 410;
  localparam logic [CMD_W-1:0]   CMD_UNUSED   = 3'd7;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   mismatches;
  int   pending;
  int   held_count;
  int   cmd_calm = 0;
  int   res_calm = 0;
  cmd_t insert_ops[3] = '{CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_POS};
  cmd_t delete_ops[3] = '{CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS};

  ple_cmd_if cmd_ch();
  ple_res_if res_ch();

  positional_list_engine dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  positional_list_engine_checker list_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_mon    (cmd_ch),
    .res_mon    (res_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .held_count (held_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic issue_command(input logic [CMD_W-1:0] code,
                               input logic signed [VALUE_W-1:0] word,
                               input logic [POS_W-1:0] pos);
    int gap;
    gap = draw_wait(cmd_calm);
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.command  <= code;
    cmd_ch.value    <= word;
    cmd_ch.position <= pos;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** positional_list_engine: FAILED **");
    $finish;
  end

  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(res_calm);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    int                       roll;
    int                       limit;
    bit                       growing;
    logic [CMD_W-1:0]         code;
    logic signed [VALUE_W-1:0] word;
    logic [POS_W-1:0]         pos;

    rst             = 1'b1;
    cmd_ch.valid    = 1'b0;
    cmd_ch.command  = CMD_INS_FIRST;
    cmd_ch.value    = '0;
    cmd_ch.position = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue_command(CMD_DUMP,      32'sd0, 8'd0);
    issue_command(CMD_DEL_FIRST, 32'sd0, 8'd0);
    issue_command(CMD_DEL_LAST,  32'sd0, 8'd0);
    issue_command(CMD_DEL_POS,   32'sd0, 8'd1);
    issue_command(CMD_DEL_POS,   32'sd0, 8'd0);
    issue_command(CMD_INS_POS,   32'sd5, 8'd0);
    issue_command(CMD_INS_POS,   32'sd5, 8'd2);
    issue_command(CMD_INS_POS,   32'sd5, 8'd255);
    issue_command(CMD_INS_FIRST, 32'sh7FFF_FFFF, 8'd0);
    issue_command(CMD_INS_LAST,  32'sh8000_0000, 8'd255);
    issue_command(CMD_INS_POS,   -32'sd1, 8'd2);
    issue_command(CMD_INS_POS,   32'sd0, 8'd4);
    issue_command(CMD_INS_POS,   32'sd1, 8'd1);
    issue_command(CMD_DUMP,      32'sd0, 8'd0);
    issue_command(CMD_DEL_POS,   32'sd0, 8'd0);
    issue_command(CMD_DEL_POS,   32'sd0, 8'd6);
    issue_command(CMD_DEL_POS,   32'sd0, 8'd255);
    issue_command(CMD_DEL_POS,   32'sd0, 8'd5);
    issue_command(CMD_DEL_POS,   32'sd0, 8'd1);
    issue_command(CMD_DEL_FIRST, 32'sd0, 8'd0);
    issue_command(CMD_DEL_LAST,  32'sd0, 8'd0);
    issue_command(CMD_UNUSED,    32'sd9, 8'd3);
    issue_command(CMD_DUMP,      32'sd0, 8'd0);
    issue_command(CMD_DEL_LAST,  32'sd0, 8'd0);
    wait_for_results();

    growing = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (growing && held_count >= CAPACITY && $urandom_range(0, 5) == 0) growing = 1'b0;
      if (!growing && held_count == 0 && $urandom_range(0, 5) == 0) growing = 1'b1;

      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        code = CMD_DUMP;
      end else if (roll < 10) begin
        code = CMD_UNUSED;
      end else if (roll < (growing ? 80 : 30)) begin
        code = insert_ops[$urandom_range(0, 2)];
      end else begin
        code = delete_ops[$urandom_range(0, 2)];
      end

      pos = POS_W'($urandom);
      if (code == CMD_INS_POS || code == CMD_DEL_POS) begin
        limit = (code == CMD_INS_POS) ? held_count + 1 : held_count;
        roll  = $urandom_range(0, 9);
        if (roll < 7 && limit >= 1) begin
          pos = POS_W'($urandom_range(1, limit));
        end else if (roll == 7) begin
          pos = '0;
        end else if (roll == 8) begin
          pos = POS_W'(limit + 1);
        end
      end

      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        word = 32'sh7FFF_FFFF;
      end else if (roll == 1) begin
        word = 32'sh8000_0000;
      end else if (roll == 2) begin
        word = '0;
      end else if (roll == 3) begin
        word = '1;
      end else begin
        word = $urandom;
      end

      issue_command(code, word, pos);
      if (n % 100 == 99) wait_for_results();
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** positional_list_engine: PASSED **");
    end else begin
      $display("** positional_list_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ple_pkg.sv
sv/ple_chan_if.sv
sv/ple_cell.sv
sv/ple_ctrl.sv
sv/positional_list_engine.sv
sim/positional_list_engine_checker.sv
sim/positional_list_engine_tb.sv
